// File: design/min_tracking_stack_assert.svh
// ---------------------------------------------------------------------------
// min tracking stack assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// same-cycle implication
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min stack check failed");

// next-cycle implication
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min stack check failed");

`endif

// File: design/min_stk_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// min stack package
// operation codes, status codes and payload types
// ---------------------------------------------------------------------------
package min_stk_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;

    // operation codes, unused code three behaves as a read
    localparam mode_t MODE_PUSH = 2'd0;
    localparam mode_t MODE_POP  = 2'd1;
    localparam mode_t MODE_READ = 2'd2;

    // status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_OVERFLOW  = 2'd1;
    localparam status_t ST_UNDERFLOW = 2'd2;

endpackage

// File: design/min_stk_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// min stack channel interfaces
// request and response channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface min_stk_req_if;
    import min_stk_pkg::*;

    logic  valid;
    logic  ready;
    mode_t mode;
    word_t push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink (input valid, input mode, input push_value, output ready);
endinterface

interface min_stk_rsp_if;
    import min_stk_pkg::*;

    logic    valid;
    logic    ready;
    word_t   top_value;
    word_t   min_value;
    logic    is_empty;
    status_t status;

    modport source (output valid, output top_value, output min_value, output is_empty,
                    output status, input ready);
    modport sink (input valid, input top_value, input min_value, input is_empty,
                  input status, output ready);
endinterface

// File: design/min_stk_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// min stack ram
// one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module min_stk_ram #(
    parameter  int DEPTH  = 64,
    parameter  int WIDTH  = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/min_tracking_stack.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// min tracking stack
// lifo of signed words that reports its top and its minimum after every op
// ---------------------------------------------------------------------------
// response: push, read, underflow pop and a pop of the last value register
//   their result at the transfer, any other pop answers from the fetch state
//   once the registered ram read of the entry below the old top has landed
// throughput: one transfer per cycle unless rsp stalls or a pop is in fetch
// reset: counters and control clear at once, the rams are not cleared and
//   need no clearing pass since only entries below the counts are read
// ---------------------------------------------------------------------------
`include "min_tracking_stack_assert.svh"

module min_tracking_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    min_stk_req_if.sink   req,
    min_stk_rsp_if.source rsp
);
    import min_stk_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // idle takes transfers, fetch waits for the ram read after a pop
    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   val_cnt_reg, val_cnt_next;
    logic [CNT_W-1:0]   min_cnt_reg, min_cnt_next;
    // cached tops of both stores, meaningful only while the counts are nonzero
    word_t              top_reg, top_next;
    word_t              min_top_reg, min_top_next;
    logic               min_pop_reg, min_pop_next;

    // response holding register
    logic               rsp_valid_reg, rsp_valid_next;
    word_t              rsp_top_reg, rsp_top_next;
    word_t              rsp_min_reg, rsp_min_next;
    logic               rsp_empty_reg, rsp_empty_next;
    status_t            rsp_status_reg, rsp_status_next;
    logic               rsp_load;

    // ram ports
    logic               val_wr_en, min_wr_en;
    logic               val_rd_en, min_rd_en;
    logic [CNT_W-1:0]   val_rd_idx, min_rd_idx;
    word_t              val_rd_data, min_rd_data;

    logic               req_xfer;
    logic               is_full;
    logic               min_push;

    min_stk_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_W)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (val_cnt_reg[ADDR_W-1:0]),
        .wr_data (req.push_value),
        .rd_en   (val_rd_en),
        .rd_addr (val_rd_idx[ADDR_W-1:0]),
        .rd_data (val_rd_data)
    );

    min_stk_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_W)
    ) u_min_ram (
        .clk     (clk),
        .wr_en   (min_wr_en),
        .wr_addr (min_cnt_reg[ADDR_W-1:0]),
        .wr_data (req.push_value),
        .rd_en   (min_rd_en),
        .rd_addr (min_rd_idx[ADDR_W-1:0]),
        .rd_data (min_rd_data)
    );

    // a new transfer is taken in idle once the response slot is free or drains
    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_xfer  = req.valid && req.ready;

    assign is_full  = (val_cnt_reg == CNT_W'(STACK_DEPTH));
    assign min_push = (min_cnt_reg == '0) || (req.push_value <= min_top_reg);

    // after a pop the new tops sit one below the new counts
    assign val_rd_idx = val_cnt_reg - CNT_W'(2);
    assign min_rd_idx = min_cnt_reg - CNT_W'(2);

    always_comb
    begin
        state_next      = state_reg;
        val_cnt_next    = val_cnt_reg;
        min_cnt_next    = min_cnt_reg;
        top_next        = top_reg;
        min_top_next    = min_top_reg;
        min_pop_next    = min_pop_reg;
        val_wr_en       = 1'b0;
        min_wr_en       = 1'b0;
        val_rd_en       = 1'b0;
        min_rd_en       = 1'b0;
        rsp_load        = 1'b0;
        rsp_top_next    = rsp_top_reg;
        rsp_min_next    = rsp_min_reg;
        rsp_empty_next  = rsp_empty_reg;
        rsp_status_next = rsp_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    rsp_load        = 1'b1;
                    rsp_status_next = ST_OK;
                    unique case (req.mode)
                        MODE_PUSH:
                        begin
                            if (is_full)
                            begin
                                // push dropped, full stack is never empty
                                rsp_top_next    = top_reg;
                                rsp_min_next    = (min_cnt_reg == '0) ? '0 : min_top_reg;
                                rsp_empty_next  = 1'b0;
                                rsp_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                val_wr_en    = 1'b1;
                                val_cnt_next = val_cnt_reg + CNT_W'(1);
                                top_next     = req.push_value;
                                if (min_push)
                                begin
                                    min_wr_en    = 1'b1;
                                    min_cnt_next = min_cnt_reg + CNT_W'(1);
                                    min_top_next = req.push_value;
                                end
                                rsp_top_next   = req.push_value;
                                rsp_min_next   = min_push ? req.push_value : min_top_reg;
                                rsp_empty_next = 1'b0;
                            end
                        end
                        MODE_POP:
                        begin
                            if (val_cnt_reg == '0)
                            begin
                                rsp_top_next    = '0;
                                rsp_min_next    = '0;
                                rsp_empty_next  = 1'b1;
                                rsp_status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                val_cnt_next = val_cnt_reg - CNT_W'(1);
                                min_pop_next = (min_cnt_reg != '0) && (min_top_reg == top_reg);
                                if (min_pop_next)
                                begin
                                    min_cnt_next = min_cnt_reg - CNT_W'(1);
                                end
                                if (val_cnt_reg == CNT_W'(1))
                                begin
                                    // last value removed, answer at once
                                    rsp_top_next   = '0;
                                    rsp_min_next   = '0;
                                    rsp_empty_next = 1'b1;
                                end
                                else
                                begin
                                    // fetch the entries below the old tops
                                    rsp_load   = 1'b0;
                                    val_rd_en  = 1'b1;
                                    min_rd_en  = min_pop_next && (min_cnt_reg > CNT_W'(1));
                                    state_next = S_FETCH;
                                end
                            end
                        end
                        default:
                        begin
                            // plain read, unused code included
                            rsp_empty_next = (val_cnt_reg == '0);
                            rsp_top_next   = (val_cnt_reg == '0) ? '0 : top_reg;
                            rsp_min_next   = (val_cnt_reg == '0 || min_cnt_reg == '0) ?
                                             '0 : min_top_reg;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                // read data landed, refresh the cached tops and answer
                top_next = val_rd_data;
                if (min_pop_reg && min_cnt_reg != '0)
                begin
                    min_top_next = min_rd_data;
                end
                rsp_load        = 1'b1;
                rsp_top_next    = val_rd_data;
                rsp_min_next    = (min_cnt_reg == '0) ? '0 :
                                  (min_pop_reg ? min_rd_data : min_top_reg);
                rsp_empty_next  = 1'b0;
                rsp_status_next = ST_OK;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            val_cnt_reg   <= '0;
            min_cnt_reg   <= '0;
            min_pop_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            val_cnt_reg   <= val_cnt_next;
            min_cnt_reg   <= min_cnt_next;
            min_pop_reg   <= min_pop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        min_top_reg    <= min_top_next;
        rsp_top_reg    <= rsp_top_next;
        rsp_min_reg    <= rsp_min_next;
        rsp_empty_reg  <= rsp_empty_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.top_value = rsp_top_reg;
    assign rsp.min_value = rsp_min_reg;
    assign rsp.is_empty  = rsp_empty_reg;
    assign rsp.status    = rsp_status_reg;

    // minimum store never holds more entries than the value store
    `MTS_ASSERT_NOW(a_min_cnt_bound, clk, rst_n, 1'b1, min_cnt_reg <= val_cnt_reg)
    // both stores empty together
    `MTS_ASSERT_NOW(a_empty_match, clk, rst_n, 1'b1, (val_cnt_reg == '0) == (min_cnt_reg == '0))
    // value count stays within the depth
    `MTS_ASSERT_NOW(a_depth_bound, clk, rst_n, 1'b1, val_cnt_reg <= CNT_W'(STACK_DEPTH))
    // response slot is free when fetched data arrives
    `MTS_ASSERT_NOW(a_fetch_slot, clk, rst_n, state_reg == S_FETCH, !rsp_valid_reg)
    // a fetch always returns to idle with a response
    `MTS_ASSERT_NEXT(a_fetch_done, clk, rst_n, state_reg == S_FETCH,
                     state_reg == S_IDLE && rsp_valid_reg)

endmodule
